@@ rtl/core/id3tx_pkg.sv @@
package id3tx_pkg;

  localparam int CFG_W    = 28;
  localparam int TEXT_MAX = 94;

  localparam logic [27:0] MAX_TAG_RST = 28'd65536;
  localparam logic [27:0] HDR_BYTES   = 28'd10;
  localparam logic [7:0]  VER_SYNCHSAFE = 8'd4;

  localparam logic [7:0] MAGIC_0 = 8'h49;
  localparam logic [7:0] MAGIC_1 = 8'h44;
  localparam logic [7:0] MAGIC_2 = 8'h33;

  localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
  localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
  localparam logic [31:0] ID_TALB = 32'h5441_4C42;

  localparam logic [3:0] IDX_MAGIC_0 = 4'd0;
  localparam logic [3:0] IDX_MAGIC_1 = 4'd1;
  localparam logic [3:0] IDX_MAGIC_2 = 4'd2;
  localparam logic [3:0] IDX_VERSION = 4'd3;
  localparam logic [3:0] IDX_FRM_ID  = 4'd3;
  localparam logic [3:0] IDX_FRM_SZ  = 4'd7;
  localparam logic [3:0] IDX_LAST    = 4'd9;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_TIT2 = 2'd1;
  localparam logic [1:0] KIND_TPE1 = 2'd2;
  localparam logic [1:0] KIND_TALB = 2'd3;

  localparam logic [2:0] ST_WALKED     = 3'd0;
  localparam logic [2:0] ST_NO_MAGIC   = 3'd1;
  localparam logic [2:0] ST_BAD_TAG_SZ = 3'd2;
  localparam logic [2:0] ST_PADDING    = 3'd3;
  localparam logic [2:0] ST_BAD_FRM_SZ = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_TAGHDR   = 3'd1,
    PH_FRAMEHDR = 3'd2,
    PH_BODY     = 3'd3,
    PH_DONE     = 3'd4
  } id3tx_phase_t;

  typedef struct packed {
    id3tx_phase_t phase;
    logic [3:0]   byte_index;
    logic [31:0]  header_shift;
    logic         ver4;
    logic [27:0]  tag_size;
    logic [27:0]  consumed;
    logic [31:0]  frame_size;
    logic [27:0]  frame_offset;
    logic [1:0]   frame_kind;
    logic [2:0]   done_flags;
    logic         text_stopped;
    logic         text_nonempty;
  } id3tx_state_t;

  typedef struct packed {
    logic [1:0] field_id;
    logic [7:0] text_byte;
    logic       byte_valid;
    logic       field_end;
    logic       done_res;
    logic [2:0] status;
  } id3tx_res_t;

  function automatic logic [27:0] synchsafe(input logic [31:0] v);
    return {v[30:24], v[22:16], v[14:8], v[6:0]};
  endfunction

endpackage

@@ rtl/core/id3tx_ifs.sv @@
interface id3tx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink (input valid, input data_byte, input file_start, output ready);
endinterface

interface id3tx_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] field_id;
  logic [7:0] text_byte;
  logic       byte_valid;
  logic       field_end;
  logic       done_res;
  logic [2:0] status;

  modport source (output valid, output field_id, output text_byte, output byte_valid,
                  output field_end, output done_res, output status, input ready);
  modport sink (input valid, input field_id, input text_byte, input byte_valid,
                input field_end, input done_res, input status, output ready);
endinterface

@@ rtl/core/id3v2_tag_text_extractor_unit.sv @@
// Channel   Direction  Word contents
// in_word   sink       data_byte[7:0], file_start
// out_word  source     field_id[1:0], text_byte[7:0], byte_valid, field_end,
//                      done_res, status[2:0]
// cfg       write      cfg_wr_en, cfg_wr_data[27:0] (largest accepted tag size)
//
// One input word is taken per cycle while the output is not stalled; its result,
// if any, appears in the output register on the next cycle.
// The single parser state register, fed back through its update logic, sets this rate.
// Reset is synchronous and active low; the size limit returns to 65536 and the
// parser waits for a word flagged as the start of a file.
// A stalled output holds its word and blocks input until it is taken.
module id3v2_tag_text_extractor_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  id3tx_in_if.sink                     in_word,
  id3tx_out_if.source                  out_word,
  input  logic                         cfg_wr_en,
  input  logic [id3tx_pkg::CFG_W-1:0]  cfg_wr_data
);
  import id3tx_pkg::*;

  logic [CFG_W-1:0] max_tag_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  id3tx_res_t       out_res_r;
  id3tx_res_t       step_res;
  logic             step_emit;
  logic             accept;

  assign in_word.ready = !out_valid_r || out_word.ready;
  assign accept        = in_word.valid && in_word.ready;

  id3tx_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (accept),
    .data_byte     (in_word.data_byte),
    .file_start    (in_word.file_start),
    .max_tag_bytes (max_tag_r),
    .emit          (step_emit),
    .res           (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tag_r <= MAX_TAG_RST;
    end else if (cfg_wr_en) begin
      max_tag_r <= cfg_wr_data;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = step_emit;
    end else if (out_word.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && step_emit) begin
      out_res_r <= step_res;
    end
  end

  assign out_word.valid      = out_valid_r;
  assign out_word.field_id   = out_res_r.field_id;
  assign out_word.text_byte  = out_res_r.text_byte;
  assign out_word.byte_valid = out_res_r.byte_valid;
  assign out_word.field_end  = out_res_r.field_end;
  assign out_word.done_res   = out_res_r.done_res;
  assign out_word.status     = out_res_r.status;

`ifndef SYNTHESIS
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && step_emit) |=> out_valid_r)
    else $error("accepted word with a result did not show it");

  a_silent_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !step_emit) |=> !out_valid_r)
    else $error("word without a result left the output valid");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_word.ready) |-> !in_word.ready)
    else $error("input taken while the output is stalled");

  a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.byte_valid) |-> (out_res_r.text_byte != 8'd0 &&
                                               out_res_r.field_id != KIND_TALB))
    else $error("text character word carries a NUL or a bad field");
`endif

endmodule

@@ rtl/core/id3tx_parser.sv @@
module id3tx_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  logic [7:0]                    data_byte,
  input  logic                          file_start,
  input  logic [id3tx_pkg::CFG_W-1:0]   max_tag_bytes,
  output logic                          emit,
  output id3tx_pkg::id3tx_res_t         res
);
  import id3tx_pkg::*;

  id3tx_state_t state_r;
  id3tx_state_t state_nxt;

  id3tx_state_t s;
  logic [31:0]  hs;
  logic [27:0]  ts;
  logic [27:0]  cons;
  logic [27:0]  rem;
  logic [28:0]  cons_end;
  logic [1:0]   fid;
  logic         last;
  logic         dn;
  logic [2:0]   st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (step_en) begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    s = state_r;
    if (file_start) begin
      s       = '0;
      s.phase = PH_TAGHDR;
    end
    state_nxt = s;
    res       = '0;
    emit      = 1'b0;
    dn        = 1'b0;
    st        = ST_WALKED;
    hs        = {s.header_shift[23:0], data_byte};
    ts        = synchsafe(hs);
    cons      = s.consumed + HDR_BYTES;
    rem       = s.tag_size - cons;
    fid       = s.frame_kind - 2'd1;
    last      = (s.frame_offset == (s.frame_size[27:0] - 28'd1));
    cons_end  = {1'b0, s.consumed} + {1'b0, s.frame_size[27:0]};

    case (s.phase)
      PH_TAGHDR: begin
        state_nxt.header_shift = hs;
        if ((s.byte_index == IDX_MAGIC_0 && data_byte != MAGIC_0) ||
            (s.byte_index == IDX_MAGIC_1 && data_byte != MAGIC_1) ||
            (s.byte_index == IDX_MAGIC_2 && data_byte != MAGIC_2)) begin
          dn = 1'b1;
          st = ST_NO_MAGIC;
        end else if (s.byte_index == IDX_VERSION) begin
          state_nxt.ver4 = (data_byte >= VER_SYNCHSAFE);
        end else if (s.byte_index == IDX_LAST) begin
          state_nxt.tag_size = ts;
          state_nxt.consumed = '0;
          if (ts == 28'd0 || ts > max_tag_bytes) begin
            dn = 1'b1;
            st = ST_BAD_TAG_SZ;
          end else if (ts < HDR_BYTES) begin
            dn = 1'b1;
            st = ST_WALKED;
          end else begin
            state_nxt.phase = PH_FRAMEHDR;
          end
        end
        state_nxt.byte_index = s.byte_index + 4'd1;
        if (state_nxt.phase == PH_FRAMEHDR) begin
          state_nxt.byte_index = '0;
        end
      end
      PH_FRAMEHDR: begin
        state_nxt.header_shift = hs;
        if (s.byte_index == IDX_FRM_ID) begin
          if (hs[31:24] == 8'd0 || hs[23:16] == 8'd0 || hs[15:8] == 8'd0 ||
              hs[7:0] == 8'd0) begin
            dn = 1'b1;
            st = ST_PADDING;
          end
          if (hs == ID_TIT2) begin
            state_nxt.frame_kind = KIND_TIT2;
          end else if (hs == ID_TPE1) begin
            state_nxt.frame_kind = KIND_TPE1;
          end else if (hs == ID_TALB) begin
            state_nxt.frame_kind = KIND_TALB;
          end else begin
            state_nxt.frame_kind = KIND_NONE;
          end
        end else if (s.byte_index == IDX_FRM_SZ) begin
          state_nxt.frame_size = s.ver4 ? {4'd0, ts} : hs;
        end else if (s.byte_index == IDX_LAST) begin
          state_nxt.consumed = cons;
          if (s.frame_size == 32'd0 || s.frame_size > {4'd0, rem}) begin
            dn = 1'b1;
            st = ST_BAD_FRM_SZ;
          end else begin
            state_nxt.phase         = PH_BODY;
            state_nxt.frame_offset  = '0;
            state_nxt.text_stopped  = 1'b0;
            state_nxt.text_nonempty = 1'b0;
          end
        end
        state_nxt.byte_index = s.byte_index + 4'd1;
      end
      PH_BODY: begin
        if (s.frame_kind != KIND_NONE && !s.done_flags[fid] && !s.text_stopped &&
            s.frame_offset != 28'd0) begin
          if (data_byte == 8'd0) begin
            state_nxt.text_stopped = 1'b1;
            if (s.text_nonempty) begin
              emit                      = 1'b1;
              res.field_id              = fid;
              res.field_end             = 1'b1;
              state_nxt.done_flags[fid] = 1'b1;
            end
          end else begin
            emit                    = 1'b1;
            res.field_id            = fid;
            res.text_byte           = data_byte;
            res.byte_valid          = 1'b1;
            state_nxt.text_nonempty = 1'b1;
            if (s.frame_offset >= 28'(TEXT_MAX) || last) begin
              res.field_end             = 1'b1;
              state_nxt.text_stopped    = 1'b1;
              state_nxt.done_flags[fid] = 1'b1;
            end
          end
        end
        if (last) begin
          state_nxt.consumed = cons_end[27:0];
          if (cons_end + {1'b0, HDR_BYTES} > {1'b0, s.tag_size}) begin
            dn = 1'b1;
            st = ST_WALKED;
          end else begin
            state_nxt.phase      = PH_FRAMEHDR;
            state_nxt.byte_index = '0;
          end
        end else begin
          state_nxt.frame_offset = s.frame_offset + 28'd1;
        end
      end
      default: begin
        state_nxt = s;
      end
    endcase

    if (dn) begin
      state_nxt.phase = PH_DONE;
      emit            = 1'b1;
      res.done_res    = 1'b1;
      res.status      = st;
    end
  end

endmodule

@@ bench/id3v2_tag_text_extractor_unit_test.sv @@
module id3v2_tag_text_extractor_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import id3tx_pkg::*;

  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_WORDS  = 150;
  localparam int SHOW_ERRORS  = 10;
  localparam int N_LIMITS     = 7;
  localparam int DIR_N        = 26;

  typedef struct packed {
    logic [7:0]  data;
    logic        start;
    logic        typed;
    logic        has_res;
    id3tx_res_t  res;
  } dir_row_t;

  typedef enum int {RX_OPEN, RX_PATTERN, RX_RANDOM, RX_STARVED} rx_mode_t;

  localparam id3tx_res_t RES_NONE     = '0;
  localparam id3tx_res_t RES_NO_MAGIC = '{2'd0, 8'd0, 1'b0, 1'b0, 1'b1, ST_NO_MAGIC};
  localparam id3tx_res_t RES_BAD_SIZE = '{2'd0, 8'd0, 1'b0, 1'b0, 1'b1, ST_BAD_TAG_SZ};
  localparam id3tx_res_t RES_WALKED   = '{2'd0, 8'd0, 1'b0, 1'b0, 1'b1, ST_WALKED};

  // Bytes outside a parse, broken magic, a zero tag size, then a tag too short
  // to hold a frame.
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{8'h00,         1'b0, 1'b1, 1'b0, RES_NONE},
    '{8'hFF,         1'b1, 1'b1, 1'b1, RES_NO_MAGIC},
    '{MAGIC_0,       1'b0, 1'b1, 1'b0, RES_NONE},
    '{MAGIC_0,       1'b1, 1'b1, 1'b0, RES_NONE},
    '{MAGIC_1,       1'b0, 1'b1, 1'b0, RES_NONE},
    '{8'h00,         1'b0, 1'b1, 1'b1, RES_NO_MAGIC},
    '{MAGIC_0,       1'b1, 1'b1, 1'b0, RES_NONE},
    '{MAGIC_1,       1'b0, 1'b1, 1'b0, RES_NONE},
    '{MAGIC_2,       1'b0, 1'b1, 1'b0, RES_NONE},
    '{VER_SYNCHSAFE, 1'b0, 1'b1, 1'b0, RES_NONE},
    '{8'h00,         1'b0, 1'b1, 1'b0, RES_NONE},
    '{8'h00,         1'b0, 1'b1, 1'b0, RES_NONE},
    '{8'h00,         1'b0, 1'b1, 1'b0, RES_NONE},
    '{8'h00,         1'b0, 1'b1, 1'b0, RES_NONE},
    '{8'h00,         1'b0, 1'b1, 1'b0, RES_NONE},
    '{8'h00,         1'b0, 1'b1, 1'b1, RES_BAD_SIZE},
    '{MAGIC_0,       1'b1, 1'b1, 1'b0, RES_NONE},
    '{MAGIC_1,       1'b0, 1'b1, 1'b0, RES_NONE},
    '{MAGIC_2,       1'b0, 1'b1, 1'b0, RES_NONE},
    '{8'd3,          1'b0, 1'b1, 1'b0, RES_NONE},
    '{8'hFF,         1'b0, 1'b0, 1'b0, RES_NONE},
    '{8'hFF,         1'b0, 1'b0, 1'b0, RES_NONE},
    '{8'h00,         1'b0, 1'b1, 1'b0, RES_NONE},
    '{8'h00,         1'b0, 1'b1, 1'b0, RES_NONE},
    '{8'h00,         1'b0, 1'b1, 1'b0, RES_NONE},
    '{8'h09,         1'b0, 1'b1, 1'b1, RES_WALKED}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  id3tx_in_if  in_ch();
  id3tx_out_if out_ch();

  id3v2_tag_text_extractor_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_ch),
    .out_word   (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #2 clk = ~clk;

  id3tx_phase_t p_phase    = PH_IDLE;
  logic [3:0]   p_idx      = '0;
  logic [31:0]  p_hdr      = '0;
  logic [7:0]   p_ver      = '0;
  logic [31:0]  p_tag_size = '0;
  logic [31:0]  p_used     = '0;
  logic [31:0]  p_frm_size = '0;
  logic [31:0]  p_frm_off  = '0;
  logic [1:0]   p_kind     = KIND_NONE;
  logic [2:0]   p_taken    = '0;
  logic         p_stopped  = 1'b0;
  logic         p_nonempty = 1'b0;
  logic [CFG_W-1:0] tag_limit = MAX_TAG_RST;

  id3tx_res_t extracted_words[$];
  logic [7:0] file_bytes[$];
  logic [CFG_W-1:0] limits [N_LIMITS];

  logic       typed_on  = 1'b0;
  logic       typed_has = 1'b0;
  id3tx_res_t typed_res = '0;
  logic       rx_free   = 1'b0;

  int errors        = 0;
  int words_taken   = 0;
  int words_live    = 0;
  int results_taken = 0;
  int text_taken    = 0;
  int ends_taken    = 0;
  int end_count [5] = '{default: 0};
  int burst_left    = 0;

  function automatic logic [31:0] unpack_synchsafe(input logic [31:0] w);
    return {4'd0, w[30:24], w[22:16], w[14:8], w[6:0]};
  endfunction

  function automatic logic [31:0] pack_synchsafe(input logic [27:0] v);
    logic [31:0] w;
    w = {1'b0, v[27:21], 1'b0, v[20:14], 1'b0, v[13:7], 1'b0, v[6:0]};
    if ($urandom_range(0, 4) == 0) w = w | ($urandom & 32'h8080_8080);
    return w;
  endfunction

  function automatic bit extract_step(input logic [7:0] b, input logic fs,
                                      output id3tx_res_t r);
    logic [1:0] fid;
    logic [7:0] tb;
    logic       bv, fe, dn, last;
    logic [2:0] st;
    bit         emit;
    fid = '0; tb = '0; bv = 1'b0; fe = 1'b0; dn = 1'b0; st = ST_WALKED;
    emit = 1'b0;
    r = '0;
    if (fs) begin
      p_phase = PH_TAGHDR; p_idx = '0; p_hdr = '0; p_ver = '0; p_tag_size = '0;
      p_used = '0; p_frm_size = '0; p_frm_off = '0; p_kind = KIND_NONE;
      p_taken = '0; p_stopped = 1'b0; p_nonempty = 1'b0;
    end
    case (p_phase)
      PH_TAGHDR: begin
        p_hdr = {p_hdr[23:0], b};
        if ((p_idx == IDX_MAGIC_0 && b != MAGIC_0) ||
            (p_idx == IDX_MAGIC_1 && b != MAGIC_1) ||
            (p_idx == IDX_MAGIC_2 && b != MAGIC_2)) begin
          dn = 1'b1; st = ST_NO_MAGIC;
        end else if (p_idx == IDX_VERSION) begin
          p_ver = b;
        end else if (p_idx == IDX_LAST) begin
          p_tag_size = unpack_synchsafe(p_hdr);
          p_used = '0;
          if (p_tag_size == 0 || p_tag_size > tag_limit) begin
            dn = 1'b1; st = ST_BAD_TAG_SZ;
          end else if (p_tag_size < HDR_BYTES) begin
            dn = 1'b1; st = ST_WALKED;
          end else begin
            p_phase = PH_FRAMEHDR;
          end
        end
        p_idx = p_idx + 4'd1;
        if (p_phase == PH_FRAMEHDR) p_idx = '0;
      end
      PH_FRAMEHDR: begin
        p_hdr = {p_hdr[23:0], b};
        if (p_idx == IDX_FRM_ID) begin
          if (p_hdr[31:24] == 0 || p_hdr[23:16] == 0 || p_hdr[15:8] == 0 ||
              p_hdr[7:0] == 0) begin
            dn = 1'b1; st = ST_PADDING;
          end
          p_kind = (p_hdr == ID_TIT2) ? KIND_TIT2 : (p_hdr == ID_TPE1) ? KIND_TPE1 :
                   (p_hdr == ID_TALB) ? KIND_TALB : KIND_NONE;
        end else if (p_idx == IDX_FRM_SZ) begin
          p_frm_size = (p_ver >= VER_SYNCHSAFE) ? unpack_synchsafe(p_hdr) : p_hdr;
        end else if (p_idx == IDX_LAST) begin
          p_used = p_used + HDR_BYTES;
          if (p_frm_size == 0 || p_frm_size > p_tag_size - p_used) begin
            dn = 1'b1; st = ST_BAD_FRM_SZ;
          end else begin
            p_phase = PH_BODY; p_frm_off = '0; p_stopped = 1'b0; p_nonempty = 1'b0;
          end
        end
        p_idx = p_idx + 4'd1;
      end
      PH_BODY: begin
        last = (p_frm_off == p_frm_size - 1);
        if (p_kind != KIND_NONE && !p_taken[p_kind - 2'd1] && !p_stopped &&
            p_frm_off >= 1) begin
          fid = p_kind - 2'd1;
          if (b == 8'h00) begin
            p_stopped = 1'b1;
            if (p_nonempty) begin
              fe = 1'b1; emit = 1'b1; p_taken[fid] = 1'b1;
            end
          end else begin
            tb = b; bv = 1'b1; emit = 1'b1; p_nonempty = 1'b1;
            if (p_frm_off >= TEXT_MAX || last) begin
              fe = 1'b1; p_stopped = 1'b1; p_taken[fid] = 1'b1;
            end
          end
          if (!emit) fid = '0;
        end
        if (last) begin
          p_used = p_used + p_frm_size;
          if (p_used + HDR_BYTES > p_tag_size) begin
            dn = 1'b1; st = ST_WALKED;
          end else begin
            p_phase = PH_FRAMEHDR; p_idx = '0;
          end
        end else begin
          p_frm_off = p_frm_off + 1;
        end
      end
      default: return 1'b0;
    endcase
    if (dn) begin
      p_phase = PH_DONE;
      emit = 1'b1;
    end
    r = '{fid, tb, bv, fe, dn, st};
    return emit;
  endfunction

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= SHOW_ERRORS) $display("%s", msg);
  endfunction

  always @(posedge clk) begin : monitor
    id3tx_res_t got, want, pred;
    bit has, live;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.field_id, out_ch.text_byte, out_ch.byte_valid, out_ch.field_end,
                out_ch.done_res, out_ch.status};
        if (got.byte_valid === 1'b1) text_taken++;
        if (got.done_res === 1'b1 && got.status <= ST_BAD_FRM_SZ) end_count[got.status]++;
        if (got.done_res === 1'b1) ends_taken++;
        if (extracted_words.size() == 0) begin
          note_error($sformatf({"result word %0d with nothing predicted: ",
                                "fid=%0d text=%02h bv=%0b fe=%0b done=%0b st=%0d"},
                               results_taken, got.field_id, got.text_byte, got.byte_valid,
                               got.field_end, got.done_res, got.status));
        end else begin
          want = extracted_words.pop_front();
          if (got.field_id !== want.field_id || got.text_byte !== want.text_byte ||
              got.byte_valid !== want.byte_valid || got.field_end !== want.field_end ||
              got.done_res !== want.done_res || got.status !== want.status) begin
            note_error($sformatf({"result word %0d: expected fid=%0d text=%02h bv=%0b ",
                                  "fe=%0b done=%0b st=%0d, got fid=%0d text=%02h bv=%0b ",
                                  "fe=%0b done=%0b st=%0d"},
                                 results_taken, want.field_id, want.text_byte, want.byte_valid,
                                 want.field_end, want.done_res, want.status, got.field_id,
                                 got.text_byte, got.byte_valid, got.field_end, got.done_res,
                                 got.status));
          end
        end
        results_taken++;
      end
      if (in_ch.valid && in_ch.ready) begin
        live = in_ch.file_start || p_phase == PH_TAGHDR || p_phase == PH_FRAMEHDR ||
               p_phase == PH_BODY;
        has = extract_step(in_ch.data_byte, in_ch.file_start, pred);
        if (typed_on) begin
          has = typed_has;
          pred = typed_res;
        end
        if (has) extracted_words.push_back(pred);
        if (live) words_live++;
        words_taken++;
      end
    end
  end

  initial begin : receiver
    rx_mode_t mode;
    int left;
    logic [15:0] pat;
    mode = RX_OPEN;
    left = 0;
    pat = 16'h0001;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_free) begin
        out_ch.ready = 1'b1;
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(20, 200);
          pat = 16'($urandom) | 16'h0001;
        end
        left--;
        case (mode)
          RX_OPEN: out_ch.ready = 1'b1;
          RX_PATTERN: begin
            out_ch.ready = pat[0];
            pat = {pat[0], pat[15:1]};
          end
          RX_RANDOM: out_ch.ready = ($urandom_range(0, 9) < 7);
          default: out_ch.ready = ($urandom_range(0, 19) == 0);
        endcase
      end
    end
  end

  task automatic send_word(input logic [7:0] d, input logic s, input logic typed,
                           input logic has, input id3tx_res_t r);
    int n;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      if (n > 0) begin
        in_ch.valid = 1'b0;
        repeat (n) @(negedge clk);
      end
    end
    burst_left--;
    n = words_taken;
    in_ch.valid = 1'b1;
    in_ch.data_byte = d;
    in_ch.file_start = s;
    typed_on = typed;
    typed_has = has;
    typed_res = r;
    do @(negedge clk); while (words_taken == n);
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (extracted_words.size() != 0) @(negedge clk);
  endtask

  task automatic set_tag_limit(input logic [CFG_W-1:0] v);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    tag_limit = v;
  endtask

  task automatic build_file();
    int pick, nfr, sz, pad, pos, cut, r;
    logic [7:0] ver, b;
    logic [31:0] fid, fsz, tword;
    logic [27:0] tsz;
    logic [7:0] frames[$];
    logic [7:0] magic[3];
    magic = '{MAGIC_0, MAGIC_1, MAGIC_2};
    file_bytes.delete();
    frames.delete();
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      pos = $urandom_range(0, 2);
      for (int i = 0; i < pos; i++) file_bytes.push_back(magic[i]);
      b = 8'($urandom_range(0, 255));
      if (b == magic[pos]) b = ~b;
      file_bytes.push_back(b);
      repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (pick < 12) begin
      repeat ($urandom_range(1, 20)) file_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    r = $urandom_range(0, 9);
    ver = (r < 4) ? 8'd3 : (r < 8) ? VER_SYNCHSAFE : 8'($urandom_range(0, 255));
    if (pick < 17) begin
      tsz = 28'($urandom_range(1, 9));
      repeat (tsz) frames.push_back(8'($urandom_range(0, 255)));
    end else begin
      nfr = $urandom_range(1, 4);
      for (int f = 0; f < nfr; f++) begin
        r = $urandom_range(0, 99);
        if (r < 25) fid = ID_TIT2;
        else if (r < 50) fid = ID_TPE1;
        else if (r < 75) fid = ID_TALB;
        else if (r < 93) begin
          for (int i = 0; i < 4; i++) fid = {fid[23:0], 8'($urandom_range(8'h30, 8'h5A))};
        end else begin
          fid = $urandom;
          for (int i = 0; i < 4; i++) if (fid[8*i +: 8] == 8'h00) fid[8*i +: 8] = 8'h41;
          fid[8*$urandom_range(0, 3) +: 8] = 8'h00;
        end
        sz = ($urandom_range(0, 19) == 0) ? $urandom_range(90, 110) : $urandom_range(1, 12);
        fsz = sz;
        r = $urandom_range(0, 99);
        if (r < 4) fsz = '0;
        else if (r < 6) fsz = 32'hFFFF_FFFF;
        else if (r < 9) fsz = sz + $urandom_range(1, 600);
        if (ver >= VER_SYNCHSAFE) fsz = pack_synchsafe(fsz[27:0]);
        for (int i = 3; i >= 0; i--) frames.push_back(fid[8*i +: 8]);
        for (int i = 3; i >= 0; i--) frames.push_back(fsz[8*i +: 8]);
        frames.push_back(8'($urandom_range(0, 255)));
        frames.push_back(8'($urandom_range(0, 255)));
        frames.push_back(8'($urandom_range(0, 3)));
        r = $urandom_range(0, 99);
        for (int i = 1; i < sz; i++) begin
          b = 8'($urandom_range(1, 255));
          if (r < 12 && i == 1) b = 8'h00;
          else if (r < 30 && $urandom_range(0, 5) == 0) b = 8'h00;
          frames.push_back(b);
        end
      end
      pad = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 14);
      repeat (pad) frames.push_back(8'h00);
      tsz = 28'(frames.size());
      r = $urandom_range(0, 99);
      if (r < 8) tsz = tsz + 28'($urandom_range(1, 40));
      else if (r < 12) tsz = '1;
    end
    tword = pack_synchsafe(tsz);
    file_bytes.push_back(MAGIC_0);
    file_bytes.push_back(MAGIC_1);
    file_bytes.push_back(MAGIC_2);
    file_bytes.push_back(ver);
    file_bytes.push_back(8'($urandom_range(0, 255)));
    file_bytes.push_back(8'($urandom_range(0, 255)));
    for (int i = 3; i >= 0; i--) file_bytes.push_back(tword[8*i +: 8]);
    foreach (frames[i]) file_bytes.push_back(frames[i]);
    repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom_range(0, 255)));
    if (pick >= 17 && pick < 27) begin
      cut = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
  endtask

  initial begin : stimulus
    int hold_at, nfiles, mark;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.file_start = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    rst_n = 1'b0;
    limits = '{MAX_TAG_RST, 28'hFFF_FFFF, 28'd0, 28'd1, 28'($urandom_range(60, 400)),
               28'($urandom_range(1, 28'hFFF_FFFF)), MAX_TAG_RST};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      send_word(DIR_ROWS[i].data, DIR_ROWS[i].start, DIR_ROWS[i].typed, DIR_ROWS[i].has_res,
                DIR_ROWS[i].res);
    end

    for (int p = 0; p < N_LIMITS; p++) begin
      if (p > 0) set_tag_limit(limits[p]);
      hold_at = $urandom_range(1, 4);
      nfiles = 0;
      mark = words_taken;
      while (words_taken - mark < PHASE_WORDS) begin
        build_file();
        foreach (file_bytes[i]) send_word(file_bytes[i], i == 0, 1'b0, 1'b0, '0);
        nfiles++;
        // Hold the sender until the block has handed over every pending word.
        if (nfiles == hold_at) wait_drained();
      end
    end

    in_ch.valid = 1'b0;
    rx_free = 1'b1;
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (extracted_words.size() != 0)
      note_error($sformatf("%0d predicted words never arrived", extracted_words.size()));
    $display({"Summary: %0d input words (%0d parsed), %0d result words ",
              "(%0d text bytes, %0d tag endings), %0d size limits."},
             words_taken, words_live, results_taken, text_taken, ends_taken, N_LIMITS);
    $display({"Endings: walked %0d, no magic %0d, bad tag size %0d, padding %0d, ",
              "bad frame size %0d."},
             end_count[0], end_count[1], end_count[2], end_count[3], end_count[4]);
    if (errors == 0) begin
      $display("id3v2_tag_text_extractor_unit_test: PASS");
    end else begin
      $display("id3v2_tag_text_extractor_unit_test: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("id3v2_tag_text_extractor_unit_test: FAIL");
    $finish;
  end

endmodule
